// ===== hdl/chip8_instruction_execute_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef CHIP8_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define C8X_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define C8X_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/chip8x_pkg.sv =====
package chip8x_pkg;

  // Return stack and queue sizing
  localparam int StackDepth = 16;
  localparam int StackAw    = $clog2(StackDepth);
  localparam int StackCw    = $clog2(StackDepth + 1);
  localparam int QueueDepth = 2;
  localparam int QueueAw    = $clog2(QueueDepth);
  localparam int QueueCw    = $clog2(QueueDepth + 1);
  localparam int OutDepth   = 2;
  localparam int OutAw      = $clog2(OutDepth);
  localparam int OutCw      = $clog2(OutDepth + 1);

  // Program counter constants
  localparam logic [11:0] ResetPc = 12'd512;
  localparam logic [11:0] PcStep  = 12'd2;
  localparam logic [11:0] PcSkip  = 12'd4;

  // Whole-word opcodes
  localparam logic [15:0] OpClear  = 16'h00E0;
  localparam logic [15:0] OpReturn = 16'h00EE;

  // Opcode groups (top nibble)
  localparam logic [3:0] GrpSys  = 4'h0;
  localparam logic [3:0] GrpJp   = 4'h1;
  localparam logic [3:0] GrpCall = 4'h2;
  localparam logic [3:0] GrpSeK  = 4'h3;
  localparam logic [3:0] GrpSneK = 4'h4;
  localparam logic [3:0] GrpSeV  = 4'h5;
  localparam logic [3:0] GrpLdK  = 4'h6;
  localparam logic [3:0] GrpAddK = 4'h7;
  localparam logic [3:0] GrpAlu  = 4'h8;
  localparam logic [3:0] GrpSneV = 4'h9;
  localparam logic [3:0] GrpLdI  = 4'hA;
  localparam logic [3:0] GrpJpV0 = 4'hB;
  localparam logic [3:0] GrpRnd  = 4'hC;
  localparam logic [3:0] GrpDrw  = 4'hD;

  // ALU group sub-operations (last nibble of 8xyn)
  localparam logic [3:0] AluLd   = 4'h0;
  localparam logic [3:0] AluOr   = 4'h1;
  localparam logic [3:0] AluAnd  = 4'h2;
  localparam logic [3:0] AluXor  = 4'h3;
  localparam logic [3:0] AluAdd  = 4'h4;
  localparam logic [3:0] AluSub  = 4'h5;
  localparam logic [3:0] AluShr  = 4'h6;
  localparam logic [3:0] AluSubn = 4'h7;
  localparam logic [3:0] AluShl  = 4'hE;

  // Register number of the flag register
  localparam logic [3:0] RegF = 4'hF;

  // Display actions
  localparam logic [1:0] ActNone  = 2'd0;
  localparam logic [1:0] ActClear = 2'd1;
  localparam logic [1:0] ActDraw  = 2'd2;

  // Fault codes
  localparam logic [1:0] FaultNone  = 2'd0;
  localparam logic [1:0] FaultOver  = 2'd1;
  localparam logic [1:0] FaultUnder = 2'd2;
  localparam logic [1:0] FaultBad   = 2'd3;

  // Input item
  typedef struct packed {
    logic        command;
    logic [15:0] opcode;
    logic [7:0]  random_byte;
    logic        collision;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [11:0] next_pc;
    logic [11:0] index_value;
    logic [1:0]  display_action;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [3:0]  draw_rows;
    logic [1:0]  fault;
  } out_item_t;

  // Instruction class decided by the front end
  typedef enum logic [4:0] {
    ClsColl, ClsClear, ClsRet, ClsJp, ClsCall, ClsSeK, ClsSneK, ClsSeV, ClsSneV,
    ClsLdK, ClsAddK, ClsAlu, ClsLdI, ClsJpV0, ClsRnd, ClsDrw, ClsBad
  } cls_e;

  // Decoded instruction passed from front to back
  typedef struct packed {
    cls_e        cls;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [11:0] nnn;
    logic        coll;
  } dec_t;

endpackage

// ===== hdl/chip8x_front.sv =====
module chip8x_front (
  input  logic                 push_i,
  input  chip8x_pkg::in_item_t in_item_i,
  input  logic                 q_full_i,
  output logic                 full_o,
  output logic                 q_push_o,
  output chip8x_pkg::dec_t     q_item_o
);

  // Accept whenever the decoded-instruction queue has room
  assign full_o   = q_full_i;
  assign q_push_o = push_i & ~q_full_i;

  // Classify the instruction word and pre-select operands
  always_comb begin
    q_item_o      = '0;
    q_item_o.x    = in_item_i.opcode[11:8];
    q_item_o.y    = in_item_i.opcode[7:4];
    q_item_o.n    = in_item_i.opcode[3:0];
    q_item_o.nnn  = in_item_i.opcode[11:0];
    q_item_o.coll = in_item_i.collision;
    q_item_o.cls  = chip8x_pkg::ClsBad;
    if (in_item_i.command) begin
      q_item_o.cls = chip8x_pkg::ClsColl;
    end else if (in_item_i.opcode == chip8x_pkg::OpClear) begin
      q_item_o.cls = chip8x_pkg::ClsClear;
    end else if (in_item_i.opcode == chip8x_pkg::OpReturn) begin
      q_item_o.cls = chip8x_pkg::ClsRet;
    end else begin
      unique case (in_item_i.opcode[15:12])
        chip8x_pkg::GrpJp:   q_item_o.cls = chip8x_pkg::ClsJp;
        chip8x_pkg::GrpCall: q_item_o.cls = chip8x_pkg::ClsCall;
        chip8x_pkg::GrpSeK:  q_item_o.cls = chip8x_pkg::ClsSeK;
        chip8x_pkg::GrpSneK: q_item_o.cls = chip8x_pkg::ClsSneK;
        chip8x_pkg::GrpSeV:  q_item_o.cls = chip8x_pkg::ClsSeV;
        chip8x_pkg::GrpSneV: q_item_o.cls = chip8x_pkg::ClsSneV;
        chip8x_pkg::GrpLdK:  q_item_o.cls = chip8x_pkg::ClsLdK;
        chip8x_pkg::GrpAddK: q_item_o.cls = chip8x_pkg::ClsAddK;
        chip8x_pkg::GrpLdI:  q_item_o.cls = chip8x_pkg::ClsLdI;
        chip8x_pkg::GrpDrw:  q_item_o.cls = chip8x_pkg::ClsDrw;
        chip8x_pkg::GrpAlu: begin
          unique case (in_item_i.opcode[3:0]) inside
            chip8x_pkg::AluLd, chip8x_pkg::AluOr, chip8x_pkg::AluAnd, chip8x_pkg::AluXor,
            chip8x_pkg::AluAdd, chip8x_pkg::AluSub, chip8x_pkg::AluShr, chip8x_pkg::AluSubn,
            chip8x_pkg::AluShl: q_item_o.cls = chip8x_pkg::ClsAlu;
            default:            q_item_o.cls = chip8x_pkg::ClsBad;
          endcase
        end
        chip8x_pkg::GrpJpV0: begin
          // second read port fetches V0
          q_item_o.cls = chip8x_pkg::ClsJpV0;
          q_item_o.y   = '0;
        end
        chip8x_pkg::GrpRnd: begin
          // fold the random byte into the immediate
          q_item_o.cls      = chip8x_pkg::ClsRnd;
          q_item_o.nnn[7:0] = in_item_i.random_byte & in_item_i.opcode[7:0];
        end
        default: q_item_o.cls = chip8x_pkg::ClsBad;
      endcase
    end
  end

endmodule

// ===== hdl/chip8x_queue.sv =====
module chip8x_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  chip8x_pkg::dec_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output chip8x_pkg::dec_t data_o,
  output logic             empty_o
);

  chip8x_pkg::dec_t                   data_q [chip8x_pkg::QueueDepth];
  logic [chip8x_pkg::QueueAw-1:0]     wptr_q, rptr_q;
  logic [chip8x_pkg::QueueCw-1:0]     cnt_q;

  assign full_o  = (cnt_q == chip8x_pkg::QueueCw'(chip8x_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = data_q[rptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == chip8x_pkg::QueueAw'(chip8x_pkg::QueueDepth - 1))
                  ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == chip8x_pkg::QueueAw'(chip8x_pkg::QueueDepth - 1))
                  ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/chip8x_back.sv =====
module chip8x_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [11:0]           cfg_pc_i,
  input  chip8x_pkg::dec_t      q_item_i,
  input  logic                  q_empty_i,
  output logic                  q_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output chip8x_pkg::out_item_t out_item_o
);

  // V0..VE register file with two read ports; VF lives in its own flop
  logic [7:0]                     vmem_q [16];
  logic [15:0]                    vvld_q;
  logic [7:0]                     vf_q;

  logic [11:0]                    pc_q, idx_q;
  logic [11:0]                    stk_q [chip8x_pkg::StackDepth];
  logic [chip8x_pkg::StackCw-1:0] depth_q, depth_m1;

  // Execute stage
  logic                           e_vld_q;
  chip8x_pkg::dec_t               e_item_q;
  logic [7:0]                     opx_q, opy_q;

  // Result queue
  chip8x_pkg::out_item_t          res_q [chip8x_pkg::OutDepth];
  logic [chip8x_pkg::OutAw-1:0]   rwp_q, rrp_q;
  logic [chip8x_pkg::OutCw-1:0]   rcnt_q;

  logic                           room, e_fire, res_pop;
  logic [7:0]                     vx, vy;
  logic [8:0]                     sum9;
  logic [11:0]                    pc_inc, pc_skip, pc_n, idx_n;
  logic                           v_we, vf_we, stk_push, stk_pop, mem_we;
  logic [7:0]                     v_wd, vf_wd;
  chip8x_pkg::out_item_t          res;

  assign room    = (rcnt_q != chip8x_pkg::OutCw'(chip8x_pkg::OutDepth));
  assign e_fire  = e_vld_q & room;
  assign q_pop_o = ~q_empty_i & (~e_vld_q | e_fire);
  assign res_pop = pop_i & ~empty_o;
  assign empty_o = (rcnt_q == '0);
  assign out_item_o = res_q[rrp_q];

  // Resolve operands: VF comes straight from its flop
  assign vx       = (e_item_q.x == chip8x_pkg::RegF) ? vf_q : opx_q;
  assign vy       = (e_item_q.y == chip8x_pkg::RegF) ? vf_q : opy_q;
  assign sum9     = {1'b0, vx} + {1'b0, vy};
  assign pc_inc   = pc_q + chip8x_pkg::PcStep;
  assign pc_skip  = pc_q + chip8x_pkg::PcSkip;
  assign depth_m1 = depth_q - 1'b1;
  assign mem_we   = e_fire & v_we & (e_item_q.x != chip8x_pkg::RegF);

  // Execute one instruction
  always_comb begin
    pc_n     = pc_inc;
    idx_n    = idx_q;
    v_we     = 1'b0;
    v_wd     = '0;
    vf_we    = 1'b0;
    vf_wd    = '0;
    stk_push = 1'b0;
    stk_pop  = 1'b0;
    res      = '0;
    res.display_action = chip8x_pkg::ActNone;
    res.fault          = chip8x_pkg::FaultNone;
    unique case (e_item_q.cls)
      chip8x_pkg::ClsColl: begin
        pc_n  = pc_q;
        vf_we = 1'b1;
        vf_wd = {7'b0, e_item_q.coll};
      end
      chip8x_pkg::ClsClear: res.display_action = chip8x_pkg::ActClear;
      chip8x_pkg::ClsRet: begin
        if (depth_q == '0) begin
          res.fault = chip8x_pkg::FaultUnder;
        end else begin
          stk_pop = 1'b1;
          pc_n    = stk_q[depth_m1[chip8x_pkg::StackAw-1:0]];
        end
      end
      chip8x_pkg::ClsJp: pc_n = e_item_q.nnn;
      chip8x_pkg::ClsCall: begin
        if (depth_q == chip8x_pkg::StackCw'(chip8x_pkg::StackDepth)) begin
          res.fault = chip8x_pkg::FaultOver;
        end else begin
          stk_push = 1'b1;
          pc_n     = e_item_q.nnn;
        end
      end
      chip8x_pkg::ClsSeK:  if (vx == e_item_q.nnn[7:0]) pc_n = pc_skip;
      chip8x_pkg::ClsSneK: if (vx != e_item_q.nnn[7:0]) pc_n = pc_skip;
      chip8x_pkg::ClsSeV:  if (vx == vy) pc_n = pc_skip;
      chip8x_pkg::ClsSneV: if (vx != vy) pc_n = pc_skip;
      chip8x_pkg::ClsLdK: begin
        v_we = 1'b1;
        v_wd = e_item_q.nnn[7:0];
      end
      chip8x_pkg::ClsAddK: begin
        v_we = 1'b1;
        v_wd = vx + e_item_q.nnn[7:0];
      end
      chip8x_pkg::ClsRnd: begin
        v_we = 1'b1;
        v_wd = e_item_q.nnn[7:0];
      end
      chip8x_pkg::ClsAlu: begin
        v_we = 1'b1;
        case (e_item_q.n)
          chip8x_pkg::AluLd:  v_wd = vy;
          chip8x_pkg::AluOr:  v_wd = vx | vy;
          chip8x_pkg::AluAnd: v_wd = vx & vy;
          chip8x_pkg::AluXor: v_wd = vx ^ vy;
          chip8x_pkg::AluAdd: begin
            v_wd  = sum9[7:0];
            vf_we = 1'b1;
            vf_wd = {7'b0, sum9[8]};
          end
          chip8x_pkg::AluSub: begin
            v_wd  = vx - vy;
            vf_we = 1'b1;
            vf_wd = {7'b0, (vx > vy)};
          end
          chip8x_pkg::AluShr: begin
            v_wd  = {1'b0, vx[7:1]};
            vf_we = 1'b1;
            vf_wd = {7'b0, vx[0]};
          end
          chip8x_pkg::AluSubn: begin
            v_wd  = vy - vx;
            vf_we = 1'b1;
            vf_wd = {7'b0, (vy > vx)};
          end
          chip8x_pkg::AluShl: begin
            v_wd  = {vx[6:0], 1'b0};
            vf_we = 1'b1;
            vf_wd = {7'b0, vx[7]};
          end
          default: v_we = 1'b0;
        endcase
      end
      chip8x_pkg::ClsLdI:  idx_n = e_item_q.nnn;
      chip8x_pkg::ClsJpV0: pc_n  = e_item_q.nnn + {4'b0, vy};
      chip8x_pkg::ClsDrw: begin
        res.display_action = chip8x_pkg::ActDraw;
        res.draw_x         = vx;
        res.draw_y         = vy;
        res.draw_rows      = e_item_q.n;
      end
      default: res.fault = chip8x_pkg::FaultBad;
    endcase
    res.next_pc     = pc_n;
    res.index_value = idx_n;
  end

  // Register file write and operand read with bypass of the same-cycle write
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vmem_q[e_item_q.x] <= v_wd;
    end
    if (q_pop_o) begin
      e_item_q <= q_item_i;
      if (mem_we && e_item_q.x == q_item_i.x) begin
        opx_q <= v_wd;
      end else begin
        opx_q <= vvld_q[q_item_i.x] ? vmem_q[q_item_i.x] : 8'h00;
      end
      if (mem_we && e_item_q.x == q_item_i.y) begin
        opy_q <= v_wd;
      end else begin
        opy_q <= vvld_q[q_item_i.y] ? vmem_q[q_item_i.y] : 8'h00;
      end
    end
  end

  // Return stack storage
  always_ff @(posedge clk_i) begin
    if (e_fire && stk_push) begin
      stk_q[depth_q[chip8x_pkg::StackAw-1:0]] <= pc_inc;
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (e_fire) begin
      res_q[rwp_q] <= res;
    end
  end

  // Architectural state, execute valid and result queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vvld_q  <= '0;
      vf_q    <= '0;
      pc_q    <= chip8x_pkg::ResetPc;
      idx_q   <= '0;
      depth_q <= '0;
      e_vld_q <= 1'b0;
      rwp_q   <= '0;
      rrp_q   <= '0;
      rcnt_q  <= '0;
    end else begin
      if (mem_we) begin
        vvld_q[e_item_q.x] <= 1'b1;
      end
      if (e_fire) begin
        if (v_we && e_item_q.x == chip8x_pkg::RegF) begin
          vf_q <= v_wd;
        end else if (vf_we) begin
          vf_q <= vf_wd;
        end
        idx_q <= idx_n;
        if (stk_push) begin
          depth_q <= depth_q + 1'b1;
        end else if (stk_pop) begin
          depth_q <= depth_m1;
        end
      end
      if (cfg_we_i) begin
        pc_q <= cfg_pc_i;
      end else if (e_fire) begin
        pc_q <= pc_n;
      end
      if (q_pop_o) begin
        e_vld_q <= 1'b1;
      end else if (e_fire) begin
        e_vld_q <= 1'b0;
      end
      if (e_fire) begin
        rwp_q <= (rwp_q == chip8x_pkg::OutAw'(chip8x_pkg::OutDepth - 1))
                 ? '0 : rwp_q + 1'b1;
      end
      if (res_pop) begin
        rrp_q <= (rrp_q == chip8x_pkg::OutAw'(chip8x_pkg::OutDepth - 1))
                 ? '0 : rrp_q + 1'b1;
      end
      if (e_fire && !res_pop) begin
        rcnt_q <= rcnt_q + 1'b1;
      end else if (!e_fire && res_pop) begin
        rcnt_q <= rcnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/chip8_instruction_execute_core.sv =====
// CHIP-8 execute core: while full is low, takes one instruction (or one
// collision write-back) per cycle through a push/full queue port and returns
// exactly one result per item through an empty/pop port, in order. Each result
// carries the program counter after the instruction (PC is advanced by 2 before
// every opcode), the index register, any display request (clear or draw with Vx,
// Vy and row count) and a fault code for stack overflow, stack underflow or an
// unsupported opcode. Throughput is one item per clock while the result queue
// has room, set by the single execute stage that resolves each instruction
// against the register file; items pass decode queue, execute stage, result queue.
// Writing cfg_data_i loads the program counter; do so only with the core idle.
module chip8_instruction_execute_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  chip8x_pkg::in_item_t  in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output chip8x_pkg::out_item_t out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [11:0]           cfg_data_i
);

  logic             q_push, q_full, q_pop, q_empty;
  chip8x_pkg::dec_t q_wdata, q_rdata;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  chip8x_front u_front (
    .push_i    (push),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .full_o    (full),
    .q_push_o  (q_push),
    .q_item_o  (q_wdata)
  );

  chip8x_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  chip8x_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_pc_i   (cfg_data_i),
    .q_item_i   (q_rdata),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule

// ===== hdl/chip8x_checker.sv =====
`include "chip8_instruction_execute_core_defines.svh"

module chip8x_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input chip8x_pkg::out_item_t out_item_o
);

  // Both queues come out of reset empty
  `C8X_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (empty && !full), "queues not clear in reset")

  // A waiting result holds until it is transferred
  `C8X_ASSERT(a_result_hold, (!empty && !pop) |=> (!empty && $stable(out_item_o)), "result changed while stalled")

  // Draw fields are zero unless a draw is requested
  `C8X_ASSERT(a_draw_fields, (!empty && out_item_o.display_action != chip8x_pkg::ActDraw) |-> (out_item_o.draw_x == 8'h00 && out_item_o.draw_y == 8'h00 && out_item_o.draw_rows == 4'h0), "draw fields set without draw")

  // A faulting instruction never requests the display
  `C8X_ASSERT(a_fault_quiet, (!empty && out_item_o.fault != chip8x_pkg::FaultNone) |-> (out_item_o.display_action == chip8x_pkg::ActNone), "display request on fault")

endmodule

bind chip8_instruction_execute_core chip8x_checker u_checker (.*);

// ===== sim/chip8_instruction_execute_core_test.sv =====
`timescale 1ns / 100ps

module chip8_instruction_execute_core_test;
  import chip8x_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DirectedCount = 28;

  // One directed stimulus row; want is used in place of the predictor when fixed is set
  typedef struct packed {
    in_item_t  item;
    logic      fixed;
    out_item_t want;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item_i;
  logic      empty;
  logic      pop;
  out_item_t out_item_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [11:0] cfg_data_i;

  // Shadow machine state
  logic [7:0]  vreg [16];
  logic [11:0] ireg;
  logic [11:0] pc_reg;
  logic [11:0] call_stack [StackDepth];
  int          call_depth;

  out_item_t   pending_results [$];
  out_item_t   predicted;
  out_item_t   got_result;
  out_item_t   want_result;
  logic        fixed_row;
  out_item_t   fixed_result;
  int          error_count;
  int          cycle_count;
  bit          call_heavy;
  logic [7:0]  stall_pattern;
  int          stall_span;

  chip8_instruction_execute_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Directed rows: extremes, every operation and the odd corners
  stim_row_t directed_rows [DirectedCount] = '{
    '{'{1'b0, 16'h00E0, 8'h00, 1'b0}, 1'b1,
      '{12'd514, 12'd0, ActClear, 8'd0, 8'd0, 4'd0, FaultNone}},
    '{'{1'b0, 16'h00EE, 8'h00, 1'b0}, 1'b1,
      '{12'd516, 12'd0, ActNone, 8'd0, 8'd0, 4'd0, FaultUnder}},
    '{'{1'b0, 16'hF065, 8'h00, 1'b0}, 1'b1,
      '{12'd518, 12'd0, ActNone, 8'd0, 8'd0, 4'd0, FaultBad}},
    '{'{1'b0, 16'h6AFF, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'hCB0F, 8'hF1, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h8AB4, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h8AB5, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h8AB7, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h8AB6, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h8ABE, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h8AB0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h8AB1, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h8AB2, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h8AB3, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h8ABD, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h8FA4, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h3A01, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h4A01, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h5AB7, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h9AB0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h7AFF, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'hAFFF, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'hDABF, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b1, 16'hFFFF, 8'hFF, 1'b1}, 1'b0, '0},
    '{'{1'b0, 16'hBFFF, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h2FFE, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h00EE, 8'h00, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'h1000, 8'h00, 1'b0}, 1'b0, '0}
  };

  // Execute one item on the shadow state and return the result it gives
  function automatic out_item_t execute_opcode(in_item_t it);
    logic [15:0] op;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [11:0] pc_next;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [8:0]  sum;
    logic [7:0]  res;
    logic        flag;
    bit          flag_op;
    out_item_t   r;
    op = it.opcode;
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    kk = op[7:0];
    nnn = op[11:0];
    vx = vreg[x];
    vy = vreg[y];
    r = '0;
    flag_op = 1'b0;
    res = 8'd0;
    flag = 1'b0;
    if (it.command) begin
      vreg[RegF] = {7'd0, it.collision};
    end else begin
      pc_next = pc_reg + PcStep;
      case (op[15:12])
        GrpSys: begin
          if (op == OpClear) begin
            r.display_action = ActClear;
          end else if (op == OpReturn) begin
            if (call_depth == 0) begin
              r.fault = FaultUnder;
            end else begin
              call_depth--;
              pc_next = call_stack[call_depth];
            end
          end else begin
            r.fault = FaultBad;
          end
        end
        GrpJp: pc_next = nnn;
        GrpCall: begin
          if (call_depth >= StackDepth) begin
            r.fault = FaultOver;
          end else begin
            call_stack[call_depth] = pc_next;
            call_depth++;
            pc_next = nnn;
          end
        end
        GrpSeK:  if (vx == kk) pc_next = pc_next + PcStep;
        GrpSneK: if (vx != kk) pc_next = pc_next + PcStep;
        GrpSeV:  if (vx == vy) pc_next = pc_next + PcStep;
        GrpSneV: if (vx != vy) pc_next = pc_next + PcStep;
        GrpLdK:  vreg[x] = kk;
        GrpAddK: vreg[x] = vx + kk;
        GrpAlu: begin
          case (n)
            AluLd:  vreg[x] = vy;
            AluOr:  vreg[x] = vx | vy;
            AluAnd: vreg[x] = vx & vy;
            AluXor: vreg[x] = vx ^ vy;
            AluAdd: begin
              sum = {1'b0, vx} + {1'b0, vy};
              res = sum[7:0];
              flag = sum[8];
              flag_op = 1'b1;
            end
            AluSub: begin
              res = vx - vy;
              flag = vx > vy;
              flag_op = 1'b1;
            end
            AluShr: begin
              res = vx >> 1;
              flag = vx[0];
              flag_op = 1'b1;
            end
            AluSubn: begin
              res = vy - vx;
              flag = vy > vx;
              flag_op = 1'b1;
            end
            AluShl: begin
              res = vx << 1;
              flag = vx[7];
              flag_op = 1'b1;
            end
            default: r.fault = FaultBad;
          endcase
          // Flag first, so a result in VF wins
          if (flag_op) begin
            vreg[RegF] = {7'd0, flag};
            vreg[x] = res;
          end
        end
        GrpLdI:  ireg = nnn;
        GrpJpV0: pc_next = nnn + {4'd0, vreg[0]};
        GrpRnd:  vreg[x] = it.random_byte & kk;
        GrpDrw: begin
          r.display_action = ActDraw;
          r.draw_x = vx;
          r.draw_y = vy;
          r.draw_rows = n;
        end
        default: r.fault = FaultBad;
      endcase
      pc_reg = pc_next;
    end
    r.next_pc = pc_reg;
    r.index_value = ireg;
    return r;
  endfunction

  // Build a random instruction, mostly well-formed, some pure noise
  function automatic in_item_t make_random_item();
    in_item_t    it;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [7:0]  kk;
    logic [11:0] nnn;
    int          slot;
    x = 4'($urandom);
    y = 4'($urandom);
    n = 4'($urandom);
    nnn = 12'($urandom);
    kk = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 3));
    it.command = ($urandom_range(0, 15) == 0);
    it.random_byte = 8'($urandom);
    it.collision = 1'($urandom);
    slot = $urandom_range(0, 19);
    case (slot)
      0: begin
        case ($urandom_range(0, 3))
          0: it.opcode = OpClear;
          1, 2: it.opcode = OpReturn;
          default: it.opcode = {GrpSys, nnn};
        endcase
      end
      1: it.opcode = {GrpJp, nnn};
      2: it.opcode = {GrpCall, nnn};
      3: it.opcode = call_heavy ? {GrpCall, nnn} : OpReturn;
      4: it.opcode = {GrpSeK, x, kk};
      5: it.opcode = {GrpSneK, x, kk};
      6: it.opcode = {GrpSeV, x, y, n};
      7: it.opcode = {GrpSneV, x, y, n};
      8: it.opcode = {GrpLdK, x, kk};
      9: it.opcode = {GrpAddK, x, kk};
      10, 11, 12: it.opcode = {GrpAlu, x, y, n};
      13: it.opcode = {GrpLdI, nnn};
      14: it.opcode = {GrpJpV0, nnn};
      15: it.opcode = {GrpRnd, x, kk};
      16: it.opcode = {GrpDrw, x, y, n};
      17: it.opcode = {4'($urandom_range(14, 15)), nnn};
      default: it.opcode = 16'($urandom);
    endcase
    return it;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  // Present one item and hold it until the transfer
  task automatic send_item(in_item_t it, logic fixed, out_item_t want);
    in_item_i <= it;
    fixed_row <= fixed;
    fixed_result <= want;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  task automatic hold_off(int cycles);
    push <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic load_start_address(logic [11:0] addr);
    cfg_data_i <= addr;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: rotate a stall pattern, renewed every so often
  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_pattern = 8'($urandom);
      if ($urandom_range(0, 2) == 0) stall_pattern = 8'hFF;
      if (stall_pattern == 8'h00) stall_pattern = 8'h01;
      stall_span = $urandom_range(20, 200);
    end
    stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
    stall_span--;
    pop <= stall_pattern[0];
  end

  // Watch transfers on all three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        got_result = out_item_o;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", got_result));
        end else begin
          want_result = pending_results.pop_front();
          compare_field("next_pc", 16'(got_result.next_pc), 16'(want_result.next_pc));
          compare_field("index_value", 16'(got_result.index_value),
                        16'(want_result.index_value));
          compare_field("display_action", 16'(got_result.display_action),
                        16'(want_result.display_action));
          compare_field("draw_x", 16'(got_result.draw_x), 16'(want_result.draw_x));
          compare_field("draw_y", 16'(got_result.draw_y), 16'(want_result.draw_y));
          compare_field("draw_rows", 16'(got_result.draw_rows), 16'(want_result.draw_rows));
          compare_field("fault", 16'(got_result.fault), 16'(want_result.fault));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        pc_reg = cfg_data_i;
      end
      if (push && !full) begin
        predicted = execute_opcode(in_item_i);
        pending_results.push_back(fixed_row ? fixed_result : predicted);
      end
    end
  end

  // Guard against a hang
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("chip8_instruction_execute_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    logic [11:0] phase_addr [4];
    int          phase_items [4];
    int          burst_left;
    int          gap;
    phase_addr = '{12'hFFF, 12'h000, 12'($urandom), 12'($urandom)};
    phase_items = '{400, 400, 400, 300};
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    fixed_row = 1'b0;
    fixed_result = '0;
    error_count = 0;
    cycle_count = 0;
    stall_span = 0;
    stall_pattern = 8'hFF;
    burst_left = 0;
    for (int i = 0; i < 16; i++) vreg[i] = 8'd0;
    for (int i = 0; i < StackDepth; i++) call_stack[i] = 12'd0;
    ireg = 12'd0;
    pc_reg = ResetPc;
    call_depth = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table from the reset start address
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
    end
    hold_off(1);
    drain_results();

    // Random phases, each from a fresh start address once the block is idle
    for (int p = 0; p < 4; p++) begin
      load_start_address(phase_addr[p]);
      call_heavy = (p % 2 == 0);
      for (int k = 0; k < phase_items[p]; k++) begin
        if (burst_left == 0) begin
          gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
          if (gap > 0) hold_off(gap);
          burst_left = $urandom_range(1, 24);
        end
        send_item(make_random_item(), 1'b0, '0);
        burst_left--;
      end
      hold_off(1);
      drain_results();
    end

    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("chip8_instruction_execute_core_test OK");
    end else begin
      $display("chip8_instruction_execute_core_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/chip8x_pkg.sv
hdl/chip8x_front.sv
hdl/chip8x_queue.sv
hdl/chip8x_back.sv
hdl/chip8_instruction_execute_core.sv
hdl/chip8x_checker.sv
sim/chip8_instruction_execute_core_test.sv
